// File: sv/pal_pkg.sv
// Shared constants for the positional array list: field widths and command codes.
// No dependencies; the RAM and the top level import this package.
`timescale 1ns / 1ps

package pal_pkg;

  localparam int WORD_W    = 32;
  localparam int POS_W     = 7;
  localparam int CNT_W     = 7;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

endpackage

// File: sv/pal_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the list entries.
// Depends on pal_pkg for the word width; read data is registered.
`timescale 1ns / 1ps

module pal_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [pal_pkg::WORD_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [pal_pkg::WORD_W-1:0] rd_data_o
);
  import pal_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/positional_array_list.sv
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready tuser: cmd; tdata: position, value
// m_axis    out  m_axis_tvalid/m_axis_tready tdata: ok, removed_value, count
//
// A command shifts the entries from its position to the end of the list through the RAM,
// which moves one entry per cycle over one read and one write port. An insert at the end
// shifts no entry and only writes the value; a rejected command goes straight to its result.
// Reset clears the entry count and the control state; the RAM needs no clearing.
// A result waits in the output register while the next command is being taken.
// Top level of the positional array list; depends on pal_pkg and pal_ram.
`timescale 1ns / 1ps

module positional_array_list #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pal_pkg::S_TDATA_W-1:0] s_axis_tdata,  // position[6:0], value[38:7], zero
  input  logic                          s_axis_tuser,  // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pal_pkg::M_TDATA_W-1:0] m_axis_tdata   // ok[0], removed_value[32:1], count[39:33]
);
  import pal_pkg::*;

  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     used_q, used_d;
  logic [CW-1:0]     rd_left_q, rd_left_d;
  logic              pend_q, pend_d;
  logic              m_valid_q, m_valid_d;
  logic              op_q;
  logic [WORD_W-1:0] val_q;
  logic [IW-1:0]     k_q;
  logic [IW-1:0]     rd_addr_q;
  logic [IW-1:0]     pend_addr_q;
  logic              res_ok_q;
  logic [WORD_W-1:0] res_rem_q;
  logic [M_TDATA_W-1:0] m_tdata_q;

  logic              s_acc;
  logic              out_free;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  used_x;
  logic              ins_ok;
  logic              del_ok;
  logic              cmd_ok;
  logic [IW-1:0]     k_in;
  logic              rd_en;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;
  logic              run_end;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign pos_x  = CMP_W'(s_axis_tdata[POS_W-1:0]);
  assign used_x = CMP_W'(used_q);
  assign ins_ok = (pos_x != '0) && (pos_x <= used_x + CMP_W'(1))
                  && (used_x < CMP_W'(CAPACITY));
  assign del_ok = (pos_x != '0) && (pos_x <= used_x);
  assign cmd_ok = (s_axis_tuser == CMD_INSERT) ? ins_ok : del_ok;
  assign k_in   = IW'(pos_x - CMP_W'(1));

  assign rd_en   = (state_q == ST_RUN) && (rd_left_q != '0);
  assign run_end = (state_q == ST_RUN) && (rd_left_q == '0) && !pend_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k_q;
    wr_data = val_q;
    if (state_q == ST_RUN) begin
      if (pend_q) begin
        if (op_q == CMD_INSERT) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_q + IW'(1);
          wr_data = rd_data;
        end else if (pend_addr_q != k_q) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_q - IW'(1);
          wr_data = rd_data;
        end
      end else if ((rd_left_q == '0) && (op_q == CMD_INSERT)) begin
        wr_en = 1'b1;
      end
    end
  end

  pal_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    rd_left_d = rd_left_q;
    pend_d    = rd_en;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (cmd_ok) begin
            state_d   = ST_RUN;
            rd_left_d = used_q - CW'(k_in);
            if (s_axis_tuser == CMD_INSERT) begin
              used_d = used_q + CW'(1);
            end else begin
              used_d = used_q - CW'(1);
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        if (rd_en) begin
          rd_left_d = rd_left_q - CW'(1);
        end
        if (run_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      rd_left_q <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      rd_left_q <= rd_left_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q      <= s_axis_tuser;
      val_q     <= s_axis_tdata[POS_W +: WORD_W];
      k_q       <= k_in;
      res_ok_q  <= cmd_ok;
      res_rem_q <= '0;
      if (s_axis_tuser == CMD_INSERT) begin
        rd_addr_q <= IW'(used_q - CW'(1));
      end else begin
        rd_addr_q <= k_in;
      end
    end else if (rd_en) begin
      if (op_q == CMD_INSERT) begin
        rd_addr_q <= rd_addr_q - IW'(1);
      end else begin
        rd_addr_q <= rd_addr_q + IW'(1);
      end
    end
    pend_addr_q <= rd_addr_q;
    if ((state_q == ST_RUN) && pend_q && (op_q == CMD_DELETE) && (pend_addr_q == k_q)) begin
      res_rem_q <= rd_data;
    end
    if ((state_q == ST_DONE) && out_free) begin
      m_tdata_q <= {CNT_W'(used_q), res_rem_q, res_ok_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(used_q) <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((rd_left_q == '0) && !pend_q))
    else $error("shift still in progress while idle");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_axis_tuser == CMD_INSERT) && (CMP_W'(used_q) == CMP_W'(CAPACITY)))
    |=> (!res_ok_q && (state_q == ST_DONE)))
    else $error("insert into a full list was not rejected");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_acc |=> (used_q == $past(used_q)))
    else $error("entry count changed without a transaction");

endmodule
